// ===== rtl/mpa_pkg.sv =====
// Package for the max pooling with argmax block.
// Holds sizes, field widths, the controller state type and the command and
// status structs shared by the controller and the datapath. No dependencies.
`default_nettype none

package mpa_pkg;

   // image store size and window limit
   localparam int IMAGE_WORDS = 65536;
   localparam int MAX_WINDOW  = 8;
   localparam int ADDR_W      = $clog2(IMAGE_WORDS);

   // field and register widths
   localparam int DATA_W   = 16;
   localparam int POS_W    = 8;
   localparam int CHAN_W   = 6;
   localparam int BATCH_W  = 8;
   localparam int IDX_W    = 24;
   localparam int DIM_W    = 9;
   localparam int CCNT_W   = 7;
   localparam int WIN_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // internal arithmetic widths
   localparam int BASE_W    = 12;   // output position times stride
   localparam int CHK_W     = 13;   // base plus window size
   localparam int WIN_CHK_W = 5;    // window size against MAX_WINDOW
   localparam int WC_W      = 16;   // width times channel count
   localparam int LIN_W     = 21;   // pixel index
   localparam int FULL_W    = 28;   // word index before range check

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_HEIGHT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE     = 3'd5;

   // opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_STEP_A = 9'b000000010,
      ST_STEP_B = 9'b000000100,
      ST_STEP_C = 9'b000001000,
      ST_STEP_D = 9'b000010000,
      ST_CHECK  = 9'b000100000,
      ST_SCAN   = 9'b001000000,
      ST_DRAIN  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } mpa_state_type;

   typedef struct packed {
      logic load;      // capture the accepted item
      logic step_a;    // window base and row pitch
      logic step_b;    // row products, range flags
      logic step_c;    // pixel index, batch offset
      logic step_d;    // word addresses
      logic check;     // latch error, arm scan
      logic rd_en;     // issue one window read
      logic wr_en;     // write the stored sample
      logic out_load;  // load the result register
   } mpa_cmd_type;

   typedef struct packed {
      logic err;        // item out of range
      logic is_query;   // item is a pooling query
      logic last_elem;  // current read is the last window element
   } mpa_sts_type;

endpackage

`default_nettype wire

// ===== rtl/max_pool_argmax.sv =====
// Top level of the max pooling with argmax block.
// Joins the controller (mpa_ctrl) and the datapath (mpa_dp); depends on mpa_pkg.
//
// Use:
//  - csr_*: register writes (index, data), ready always high. Write only while
//    the block is idle. Indexes beyond the register list are dropped.
//  - req_*: one item per transfer. opcode store writes one Q8.8 sample into the
//    image store; opcode query scans a win_height x win_width window at the
//    stride and returns its maximum and flat index plus the batch offset.
//  - rsp_*: one result per item, in order. Stores return zero values.
//    Out of range items return status 1 and zero values, and write nothing.
// Timing: one item at a time. During a query the scan issues one read a cycle
// from the single read port of the image store.
// The result waits in an output register; while rsp_stall is high it holds and
// the item finished next waits in its final state, with req_stall high.
// Reset: registers return to their reset values, the controller goes idle and
// no result is pending. The image store is not cleared; read only words that
// have been written.
`default_nettype none

module max_pool_argmax (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mpa_pkg::CSR_DATA_W-1:0]     csr_data,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_opcode,
   input  wire logic [mpa_pkg::POS_W-1:0]          req_row_pos,
   input  wire logic [mpa_pkg::POS_W-1:0]          req_col_pos,
   input  wire logic [mpa_pkg::CHAN_W-1:0]         req_chan_pos,
   input  wire logic signed [mpa_pkg::DATA_W-1:0]  req_sample_in,
   input  wire logic [mpa_pkg::BATCH_W-1:0]        req_batch_number,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mpa_pkg::DATA_W-1:0]       rsp_max_value,
   output logic [mpa_pkg::IDX_W-1:0]               rsp_max_index,
   output logic                                    rsp_status
);

   // commands from the controller, status back from the datapath
   mpa_pkg::mpa_cmd_type cmd;
   mpa_pkg::mpa_sts_type sts;

   // sequence each item: capture, four setup steps, check, then scan or write
   mpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // registers, address arithmetic, image store, running maximum, result
   mpa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_opcode       (req_opcode),
      .req_row_pos      (req_row_pos),
      .req_col_pos      (req_col_pos),
      .req_chan_pos     (req_chan_pos),
      .req_sample_in    (req_sample_in),
      .req_batch_number (req_batch_number),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_index    (rsp_max_index),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/mpa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for the image store; no package dependency.
`default_nettype none

module mpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mpa_dp.sv =====
// Datapath: configuration registers, item capture, address arithmetic,
// window scan with running maximum, image store and result register.
// Depends on mpa_pkg and mpa_ram.
`default_nettype none

module mpa_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mpa_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_opcode,
   input  wire logic [mpa_pkg::POS_W-1:0]        req_row_pos,
   input  wire logic [mpa_pkg::POS_W-1:0]        req_col_pos,
   input  wire logic [mpa_pkg::CHAN_W-1:0]       req_chan_pos,
   input  wire logic signed [mpa_pkg::DATA_W-1:0] req_sample_in,
   input  wire logic [mpa_pkg::BATCH_W-1:0]      req_batch_number,
   input  wire mpa_pkg::mpa_cmd_type             cmd,
   output mpa_pkg::mpa_sts_type                  sts,
   output logic signed [mpa_pkg::DATA_W-1:0]     rsp_max_value,
   output logic [mpa_pkg::IDX_W-1:0]             rsp_max_index,
   output logic                                  rsp_status
);

   localparam int ADDR_W = mpa_pkg::ADDR_W;
   localparam int BASE_W = mpa_pkg::BASE_W;
   localparam int CHK_W  = mpa_pkg::CHK_W;
   localparam int LIN_W  = mpa_pkg::LIN_W;
   localparam int FULL_W = mpa_pkg::FULL_W;
   localparam int IDX_W  = mpa_pkg::IDX_W;
   localparam int WC_W   = mpa_pkg::WC_W;
   localparam int WIN_W  = mpa_pkg::WIN_W;

   // configuration
   logic [mpa_pkg::DIM_W-1:0]  img_width_ff, img_height_ff;
   logic [mpa_pkg::CCNT_W-1:0] channel_count_ff;
   logic [WIN_W-1:0]           win_width_ff, win_height_ff, step_size_ff;

   // captured item
   logic                               op_ff;
   logic [mpa_pkg::POS_W-1:0]          row_ff, col_ff;
   logic [mpa_pkg::CHAN_W-1:0]         chan_ff;
   logic [mpa_pkg::DATA_W-1:0]         sample_ff;
   logic [mpa_pkg::BATCH_W-1:0]        batch_ff;

   // address arithmetic
   logic [BASE_W-1:0] base_r_ff, base_r_in, base_c_ff, base_c_in;
   logic [WC_W-1:0]   wc_ff, wc_in;
   logic [LIN_W-1:0]  row_first_ff, row_first_in, row_last_ff, row_last_in;
   logic [IDX_W-1:0]  hwc_ff, hwc_in;
   logic              range_ok_ff, range_ok_in;
   logic [LIN_W-1:0]  lin_first_ff, lin_first_in, lin_last_ff, lin_last_in;
   logic [IDX_W-1:0]  batch_off_ff, batch_off_in;
   logic [FULL_W-1:0] first_full_ff, first_full_in, last_full_ff, last_full_in;
   logic              err_ff, err_in;
   logic [BASE_W-1:0] row_sel;
   logic              cfg_ok, store_ok, query_ok;

   // scan
   logic [ADDR_W-1:0] row_addr_ff, row_addr_in, col_addr_ff, col_addr_in;
   logic [WIN_W-1:0]  m_ff, m_in, n_ff, n_in;
   logic              rd_pend_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [mpa_pkg::DATA_W-1:0] rd_data;
   logic signed [mpa_pkg::DATA_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] best_addr_ff, best_addr_in;
   logic              have_ff, have_in;
   logic              col_end;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff     <= 9'd8;
         img_height_ff    <= 9'd8;
         channel_count_ff <= 7'd1;
         win_width_ff     <= 4'd2;
         win_height_ff    <= 4'd2;
         step_size_ff     <= 4'd2;
      end else if (csr_valid) begin
         case (csr_index)
            mpa_pkg::REG_IMG_WIDTH:     img_width_ff     <= csr_data;
            mpa_pkg::REG_IMG_HEIGHT:    img_height_ff    <= csr_data;
            mpa_pkg::REG_CHANNEL_COUNT: channel_count_ff <= csr_data[mpa_pkg::CCNT_W-1:0];
            mpa_pkg::REG_WIN_WIDTH:     win_width_ff     <= csr_data[WIN_W-1:0];
            mpa_pkg::REG_WIN_HEIGHT:    win_height_ff    <= csr_data[WIN_W-1:0];
            mpa_pkg::REG_STEP_SIZE:     step_size_ff     <= csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // window base, row pitch
   always_comb begin
      if (op_ff == mpa_pkg::OP_QUERY) begin
         base_r_in = BASE_W'(row_ff) * BASE_W'(step_size_ff);
         base_c_in = BASE_W'(col_ff) * BASE_W'(step_size_ff);
      end else begin
         base_r_in = BASE_W'(row_ff);
         base_c_in = BASE_W'(col_ff);
      end
      wc_in = WC_W'(img_width_ff) * WC_W'(channel_count_ff);
   end

   // row products and range flags
   always_comb begin
      row_sel = (op_ff == mpa_pkg::OP_QUERY) ?
                base_r_ff + BASE_W'(win_height_ff) - BASE_W'(1) : base_r_ff;
      row_first_in = LIN_W'(base_r_ff) * LIN_W'(img_width_ff);
      row_last_in  = LIN_W'(row_sel) * LIN_W'(img_width_ff);
      hwc_in       = IDX_W'(img_height_ff) * IDX_W'(wc_ff);
      cfg_ok = (win_width_ff != '0) && (win_height_ff != '0) && (step_size_ff != '0) &&
               (mpa_pkg::WIN_CHK_W'(win_width_ff)  <= mpa_pkg::WIN_CHK_W'(mpa_pkg::MAX_WINDOW)) &&
               (mpa_pkg::WIN_CHK_W'(win_height_ff) <= mpa_pkg::WIN_CHK_W'(mpa_pkg::MAX_WINDOW));
      store_ok = (mpa_pkg::DIM_W'(row_ff) < img_height_ff) &&
                 (mpa_pkg::DIM_W'(col_ff) < img_width_ff) &&
                 (mpa_pkg::CCNT_W'(chan_ff) < channel_count_ff);
      query_ok = cfg_ok &&
                 (CHK_W'(base_r_ff) + CHK_W'(win_height_ff) <= CHK_W'(img_height_ff)) &&
                 (CHK_W'(base_c_ff) + CHK_W'(win_width_ff) <= CHK_W'(img_width_ff)) &&
                 (mpa_pkg::CCNT_W'(chan_ff) < channel_count_ff);
      range_ok_in = (op_ff == mpa_pkg::OP_QUERY) ? query_ok : store_ok;
   end

   // pixel index and batch offset
   always_comb begin
      lin_first_in = row_first_ff + LIN_W'(base_c_ff);
      lin_last_in  = row_last_ff + LIN_W'(base_c_ff);
      if (op_ff == mpa_pkg::OP_QUERY) begin
         lin_last_in = lin_last_in + LIN_W'(win_width_ff) - LIN_W'(1);
      end
      batch_off_in = IDX_W'(batch_ff) * hwc_ff;
   end

   // word addresses
   always_comb begin
      first_full_in = FULL_W'(lin_first_ff) * FULL_W'(channel_count_ff) + FULL_W'(chan_ff);
      last_full_in  = FULL_W'(lin_last_ff) * FULL_W'(channel_count_ff) + FULL_W'(chan_ff);
      err_in = !range_ok_ff || (last_full_ff >= FULL_W'(mpa_pkg::IMAGE_WORDS));
   end

   // scan counters and addresses
   always_comb begin
      col_end     = (m_ff == win_width_ff - WIN_W'(1));
      row_addr_in = row_addr_ff;
      col_addr_in = col_addr_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      if (cmd.check) begin
         row_addr_in = first_full_ff[ADDR_W-1:0];
         col_addr_in = first_full_ff[ADDR_W-1:0];
         m_in = '0;
         n_in = '0;
      end else if (cmd.rd_en) begin
         if (col_end) begin
            row_addr_in = row_addr_ff + ADDR_W'(wc_ff);
            col_addr_in = row_addr_ff + ADDR_W'(wc_ff);
            m_in = '0;
            n_in = n_ff + WIN_W'(1);
         end else begin
            col_addr_in = col_addr_ff + ADDR_W'(channel_count_ff);
            m_in = m_ff + WIN_W'(1);
         end
      end
   end

   // running maximum; first element always taken, later ones only if greater
   always_comb begin
      best_in      = best_ff;
      best_addr_in = best_addr_ff;
      have_in      = have_ff;
      if (cmd.check) begin
         have_in = 1'b0;
      end else if (rd_pend_ff) begin
         if (!have_ff || ($signed(rd_data) > best_ff)) begin
            best_in      = $signed(rd_data);
            best_addr_in = rd_addr_ff;
            have_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
         have_ff    <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         row_ff    <= req_row_pos;
         col_ff    <= req_col_pos;
         chan_ff   <= req_chan_pos;
         sample_ff <= req_sample_in;
         batch_ff  <= req_batch_number;
      end
      if (cmd.step_a) begin
         base_r_ff <= base_r_in;
         base_c_ff <= base_c_in;
         wc_ff     <= wc_in;
      end
      if (cmd.step_b) begin
         row_first_ff <= row_first_in;
         row_last_ff  <= row_last_in;
         hwc_ff       <= hwc_in;
         range_ok_ff  <= range_ok_in;
      end
      if (cmd.step_c) begin
         lin_first_ff <= lin_first_in;
         lin_last_ff  <= lin_last_in;
         batch_off_ff <= batch_off_in;
      end
      if (cmd.step_d) begin
         first_full_ff <= first_full_in;
         last_full_ff  <= last_full_in;
      end
      if (cmd.check) begin
         err_ff <= err_in;
      end
      row_addr_ff  <= row_addr_in;
      col_addr_ff  <= col_addr_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      rd_addr_ff   <= col_addr_ff;
      best_ff      <= best_in;
      best_addr_ff <= best_addr_in;
      if (cmd.out_load) begin
         if (err_ff) begin
            rsp_max_value <= '0;
            rsp_max_index <= '0;
            rsp_status    <= mpa_pkg::STATUS_RANGE;
         end else if (op_ff == mpa_pkg::OP_QUERY) begin
            rsp_max_value <= best_ff;
            rsp_max_index <= IDX_W'(best_addr_ff) + batch_off_ff;
            rsp_status    <= mpa_pkg::STATUS_OK;
         end else begin
            rsp_max_value <= '0;
            rsp_max_index <= '0;
            rsp_status    <= mpa_pkg::STATUS_OK;
         end
      end
   end

   assign sts.err       = err_in;
   assign sts.is_query  = (op_ff == mpa_pkg::OP_QUERY);
   assign sts.last_elem = col_end && (n_ff == win_height_ff - WIN_W'(1));

   mpa_ram #(
      .WIDTH (mpa_pkg::DATA_W),
      .DEPTH (mpa_pkg::IMAGE_WORDS)
   ) u_image_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (first_full_ff[ADDR_W-1:0]),
      .wr_data (sample_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (col_addr_ff),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/mpa_ctrl.sv =====
// Controller: sequences setup, range check, store write or window scan,
// and drives the request stall and the result valid.
// Depends on mpa_pkg.
`default_nettype none

module mpa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output mpa_pkg::mpa_cmd_type      cmd,
   input  wire mpa_pkg::mpa_sts_type sts
);

   mpa_pkg::mpa_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != mpa_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mpa_pkg::ST_STEP_A;
            end
         end
         mpa_pkg::ST_STEP_A: begin
            cmd.step_a = 1'b1;
            state_in   = mpa_pkg::ST_STEP_B;
         end
         mpa_pkg::ST_STEP_B: begin
            cmd.step_b = 1'b1;
            state_in   = mpa_pkg::ST_STEP_C;
         end
         mpa_pkg::ST_STEP_C: begin
            cmd.step_c = 1'b1;
            state_in   = mpa_pkg::ST_STEP_D;
         end
         mpa_pkg::ST_STEP_D: begin
            cmd.step_d = 1'b1;
            state_in   = mpa_pkg::ST_CHECK;
         end
         mpa_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.err || !sts.is_query) begin
               cmd.wr_en = !sts.err;
               state_in  = mpa_pkg::ST_FINISH;
            end else begin
               state_in = mpa_pkg::ST_SCAN;
            end
         end
         mpa_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (sts.last_elem) begin
               state_in = mpa_pkg::ST_DRAIN;
            end
         end
         mpa_pkg::ST_DRAIN: begin
            // last read data lands in the running maximum
            state_in = mpa_pkg::ST_FINISH;
         end
         mpa_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = mpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register loaded over an unsent result");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == mpa_pkg::ST_STEP_A))
      else $error("accepted item did not start setup");

   a_drain_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpa_pkg::ST_DRAIN) |=> (state_ff == mpa_pkg::ST_FINISH))
      else $error("drain did not lead to finish");

   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (!sts.err && !sts.is_query))
      else $error("image write for a query or an out of range store");
`endif

endmodule

`default_nettype wire
